// ===== hdl/ocrb_pkg.sv =====
// -----------------------------------------------------------------------------
// ocrb_pkg
// Types and codes shared by the offset-chained reorder buffer files.
// -----------------------------------------------------------------------------
package ocrb_pkg;

	localparam logic       KIND_RELEASE = 1'b0;
	localparam logic       KIND_STATUS  = 1'b1;

	localparam logic [1:0] ST_STORED    = 2'd0;
	localparam logic [1:0] ST_DUP       = 2'd1;
	localparam logic [1:0] ST_FULL      = 2'd2;

	typedef struct packed {
		logic [63:0] window_begin;
		logic [63:0] window_end;
		logic [15:0] batch_tag;
		logic        has_updates;
	} ocrb_in_t;

	typedef struct packed {
		logic        item_kind;
		logic [63:0] out_begin;
		logic [63:0] out_end;
		logic [15:0] out_tag;
		logic        write_needed;
		logic [1:0]  input_status;
		logic        last_of_run;
	} ocrb_out_t;

	// one stored batch as it sits in the entry RAM
	typedef struct packed {
		logic [63:0] begin_ofs;
		logic [63:0] end_ofs;
		logic [15:0] tag;
		logic        has_upd;
	} ocrb_entry_t;

	localparam int ENTRY_W = $bits(ocrb_entry_t);

	// item handed from the sequencer to the output register
	typedef struct packed {
		logic      valid;
		ocrb_out_t item;
	} ocrb_emit_t;

endpackage

// ===== hdl/ocrb_chan_if.sv =====
// -----------------------------------------------------------------------------
// ocrb_chan_if
// Valid/ready channel carrying one payload item per handshake.
// -----------------------------------------------------------------------------
interface ocrb_chan_if #(
	parameter type T_t = logic
) ();

	logic valid;
	logic ready;
	T_t   data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);

endinterface

// ===== hdl/ocrb_ram.sv =====
// -----------------------------------------------------------------------------
// ocrb_ram
// Generic simple dual-port RAM, one write and one registered read port.
// -----------------------------------------------------------------------------
module ocrb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== hdl/ocrb_ctrl.sv =====
// -----------------------------------------------------------------------------
// ocrb_ctrl
// Sequencer: key scans over the entry RAM, insert, chained release, status.
// -----------------------------------------------------------------------------
module ocrb_ctrl
	import ocrb_pkg::*;
#(
	parameter int STORE_DEPTH = 16,
	localparam int IDX_W = $clog2(STORE_DEPTH)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  ocrb_in_t           in_data,
	input  logic               cfg_we,
	input  logic [63:0]        cfg_wdata,
	input  logic               out_free,
	output ocrb_emit_t         emit,
	output logic               ram_we,
	output logic [IDX_W-1:0]   ram_waddr,
	output logic [ENTRY_W-1:0] ram_wdata,
	output logic               ram_re,
	output logic [IDX_W-1:0]   ram_raddr,
	input  logic [ENTRY_W-1:0] ram_rdata
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_STORE,
		S_EMIT_REL,
		S_EMIT_STS
	} state_t;

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(STORE_DEPTH - 1);

	state_t                 state_q;
	logic [STORE_DEPTH-1:0] valid_q;
	logic [63:0]            expected_q;
	logic [63:0]            key_q;
	logic                   rel_mode_q;
	logic [IDX_W-1:0]       idx_q;
	logic                   issuing_q;
	logic                   free_ok_q;
	logic [IDX_W-1:0]       free_idx_q;
	logic [1:0]             status_q;
	ocrb_in_t               in_q;
	ocrb_entry_t            hit_entry_q;
	logic [IDX_W-1:0]       hit_idx_q;
	logic                   cmp_act_s1;
	logic                   cmp_vld_s1;
	logic [IDX_W-1:0]       cmp_idx_s1;

	ocrb_entry_t entry_rd;
	ocrb_entry_t entry_wr;
	logic        hit;
	logic        scan_done;

	always_comb begin
		entry_rd  = ocrb_entry_t'(ram_rdata);
		hit       = (state_q == S_SCAN) && cmp_vld_s1 && (entry_rd.begin_ofs == key_q);
		// last read compared, nothing matched
		scan_done = (state_q == S_SCAN) && cmp_act_s1 && !issuing_q && !hit;

		in_ready  = (state_q == S_IDLE);

		ram_re    = (state_q == S_SCAN) && issuing_q;
		ram_raddr = idx_q;

		entry_wr.begin_ofs = in_q.window_begin;
		entry_wr.end_ofs   = in_q.window_end;
		entry_wr.tag       = in_q.batch_tag;
		entry_wr.has_upd   = in_q.has_updates;
		ram_we    = (state_q == S_STORE) && free_ok_q;
		ram_waddr = free_idx_q;
		ram_wdata = entry_wr;

		emit = '0;
		if (state_q == S_EMIT_REL && out_free) begin
			emit.valid             = 1'b1;
			emit.item.item_kind    = KIND_RELEASE;
			emit.item.out_begin    = hit_entry_q.begin_ofs;
			emit.item.out_end      = hit_entry_q.end_ofs;
			emit.item.out_tag      = hit_entry_q.tag;
			emit.item.write_needed = hit_entry_q.has_upd;
		end else if (state_q == S_EMIT_STS && out_free) begin
			emit.valid             = 1'b1;
			emit.item.item_kind    = KIND_STATUS;
			emit.item.input_status = status_q;
			emit.item.last_of_run  = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			valid_q     <= '0;
			expected_q  <= '0;
			key_q       <= '0;
			rel_mode_q  <= 1'b0;
			idx_q       <= '0;
			issuing_q   <= 1'b0;
			free_ok_q   <= 1'b0;
			free_idx_q  <= '0;
			status_q    <= ST_STORED;
			in_q        <= '0;
			hit_entry_q <= '0;
			hit_idx_q   <= '0;
			cmp_act_s1  <= 1'b0;
			cmp_vld_s1  <= 1'b0;
			cmp_idx_s1  <= '0;
		end else begin
			// compare stage lines up with the registered RAM read
			cmp_act_s1 <= ram_re && !hit;
			cmp_vld_s1 <= ram_re && valid_q[idx_q] && !hit;
			cmp_idx_s1 <= idx_q;

			if (cfg_we) begin
				expected_q <= cfg_wdata;
			end

			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						in_q       <= in_data;
						key_q      <= in_data.window_begin;
						rel_mode_q <= 1'b0;
						free_ok_q  <= 1'b0;
						idx_q      <= '0;
						issuing_q  <= 1'b1;
						state_q    <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (issuing_q) begin
						idx_q <= IDX_W'(idx_q + 1'b1);
						if (idx_q == LAST_IDX) begin
							issuing_q <= 1'b0;
						end
						// lowest free slot, noted on the duplicate scan
						if (!rel_mode_q && !valid_q[idx_q] && !free_ok_q) begin
							free_ok_q  <= 1'b1;
							free_idx_q <= idx_q;
						end
					end
					if (hit) begin
						if (!rel_mode_q) begin
							status_q   <= ST_DUP;
							key_q      <= expected_q;
							rel_mode_q <= 1'b1;
							idx_q      <= '0;
							issuing_q  <= 1'b1;
						end else begin
							hit_entry_q <= entry_rd;
							hit_idx_q   <= cmp_idx_s1;
							issuing_q   <= 1'b0;
							state_q     <= S_EMIT_REL;
						end
					end else if (scan_done) begin
						state_q <= rel_mode_q ? S_EMIT_STS : S_STORE;
					end
				end
				S_STORE: begin
					if (free_ok_q) begin
						valid_q[free_idx_q] <= 1'b1;
						status_q            <= ST_STORED;
					end else begin
						status_q <= ST_FULL;
					end
					key_q      <= expected_q;
					rel_mode_q <= 1'b1;
					idx_q      <= '0;
					issuing_q  <= 1'b1;
					state_q    <= S_SCAN;
				end
				S_EMIT_REL: begin
					if (out_free) begin
						valid_q[hit_idx_q] <= 1'b0;
						expected_q         <= hit_entry_q.end_ofs;
						key_q              <= hit_entry_q.end_ofs;
						idx_q              <= '0;
						issuing_q          <= 1'b1;
						state_q            <= S_SCAN;
					end
				end
				S_EMIT_STS: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// an item is only handed over when the output register can take it
	a_emit_space: assert property (@(posedge clk) disable iff (!arst_n)
		emit.valid |-> out_free)
		else $error("item emitted into a full output register");

	// inserts only go to a free slot
	a_store_free: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> !valid_q[ram_waddr])
		else $error("insert overwrites a live entry");

	// a released entry leaves the store
	a_release_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(emit.valid && emit.item.item_kind == KIND_RELEASE) |=> !valid_q[$past(hit_idx_q)])
		else $error("released entry still valid");

	// the status item closes the run and frees the input side
	a_status_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(emit.valid && emit.item.last_of_run) |=> in_ready)
		else $error("input not ready after status item");

endmodule

// ===== hdl/offset_chained_reorder_buffer_core.sv =====
// -----------------------------------------------------------------------------
// offset_chained_reorder_buffer_core
// Reorder buffer keyed by window begin offset; releases batches in offset
// chain order and closes each input's run with a status item.
// -----------------------------------------------------------------------------
//  channel  | dir | handshake        | payload
//  ---------+-----+------------------+---------------------------------------
//  batch    | in  | valid/ready      | window_begin, window_end, batch_tag,
//           |     |                  | has_updates
//  result   | out | valid/ready      | item_kind, out_begin, out_end, out_tag,
//           |     |                  | write_needed, input_status, last_of_run
//  cfg      | in  | cfg_we/cfg_wdata | start_offset, no read-back
//
// One batch at a time. Every key search reads the entry RAM from slot 0 at one
// read a cycle and ends at the first match or after the last slot.
// A result stall holds the sequencer at the next item it wants to emit.
// After reset the store is empty and the expected offset is 0; no clearing pass.
// -----------------------------------------------------------------------------
module offset_chained_reorder_buffer_core
	import ocrb_pkg::*;
#(
	parameter int STORE_DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [63:0] cfg_wdata,
	ocrb_chan_if.sink   batch,
	ocrb_chan_if.source result
);

	localparam int IDX_W = $clog2(STORE_DEPTH);

	ocrb_emit_t         emit;
	logic               out_free;
	logic               out_valid_q;
	ocrb_out_t          out_q;
	logic               ram_we;
	logic [IDX_W-1:0]   ram_waddr;
	logic [ENTRY_W-1:0] ram_wdata;
	logic               ram_re;
	logic [IDX_W-1:0]   ram_raddr;
	logic [ENTRY_W-1:0] ram_rdata;

	ocrb_ctrl #(
		.STORE_DEPTH (STORE_DEPTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (batch.valid),
		.in_ready  (batch.ready),
		.in_data   (batch.data),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.out_free  (out_free),
		.emit      (emit),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata)
	);

	ocrb_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (STORE_DEPTH)
	) u_entry_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// output register: refilled in the cycle the held item leaves
	assign out_free     = !out_valid_q || result.ready;
	assign result.valid = out_valid_q;
	assign result.data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else if (emit.valid) begin
			out_valid_q <= 1'b1;
			out_q       <= emit.item;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule

// ===== tb/offset_chained_reorder_buffer_core_test.sv =====
// -----------------------------------------------------------------------------
// offset_chained_reorder_buffer_core_test
// Self-checking bench for the offset-chained reorder buffer. Batches go in
// through the valid/ready batch channel. A behavioral copy of the keyed store
// and the offset cursor predicts every release item and the closing status
// item. Each result is checked against that prediction in order. Directed
// cases cover the corners, then random offset chains, noise and drains run
// with random idling on both channels.
// -----------------------------------------------------------------------------
package ocrb_check_pkg;
	import ocrb_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int STORE_SLOTS = 16;
	localparam int MAX_REPORTS = 100;

	class release_predictor;
		bit        slot_used  [STORE_SLOTS];
		bit [63:0] slot_begin [STORE_SLOTS];
		bit [63:0] slot_end   [STORE_SLOTS];
		bit [15:0] slot_tag   [STORE_SLOTS];
		bit        slot_upd   [STORE_SLOTS];
		bit [63:0] next_offset;
		ocrb_out_t awaited[$];
		int errors;
		int batches_in;
		int results_seen;
		int releases_seen;
		int n_stored;
		int n_dup;
		int n_full;
		int longest_run;

		function void load_start(bit [63:0] ofs);
			next_offset = ofs;
		endfunction

		function int find_key(bit [63:0] key);
			int i;
			for (i = 0; i < STORE_SLOTS; i++)
				if (slot_used[i] && slot_begin[i] == key)
					return i;
			return -1;
		endfunction

		function int occupancy();
			int i;
			int n;
			n = 0;
			for (i = 0; i < STORE_SLOTS; i++)
				n += int'(slot_used[i]);
			return n;
		endfunction

		function bit [63:0] some_key();
			int i;
			for (i = 0; i < STORE_SLOTS; i++)
				if (slot_used[i])
					return slot_begin[i];
			return '0;
		endfunction

		// store or drop the batch, then release the chain from the cursor
		function void accept_batch(ocrb_in_t b);
			int        hit;
			int        slot;
			int        i;
			int        run;
			logic [1:0] status;
			ocrb_out_t o;
			batches_in++;
			slot = -1;
			if (find_key(b.window_begin) >= 0) begin
				status = ST_DUP;
				n_dup++;
			end else begin
				for (i = 0; i < STORE_SLOTS; i++)
					if (!slot_used[i] && slot < 0)
						slot = i;
				if (slot < 0) begin
					status = ST_FULL;
					n_full++;
				end else begin
					slot_used[slot]  = 1'b1;
					slot_begin[slot] = b.window_begin;
					slot_end[slot]   = b.window_end;
					slot_tag[slot]   = b.batch_tag;
					slot_upd[slot]   = b.has_updates;
					status = ST_STORED;
					n_stored++;
				end
			end
			run = 0;
			while (run < STORE_SLOTS) begin
				hit = find_key(next_offset);
				if (hit < 0)
					break;
				slot_used[hit] = 1'b0;
				o = '0;
				o.item_kind    = KIND_RELEASE;
				o.out_begin    = slot_begin[hit];
				o.out_end      = slot_end[hit];
				o.out_tag      = slot_tag[hit];
				o.write_needed = slot_upd[hit];
				awaited.insert(awaited.size(), o);
				next_offset = slot_end[hit];
				run++;
			end
			o = '0;
			o.item_kind    = KIND_STATUS;
			o.input_status = status;
			o.last_of_run  = 1'b1;
			awaited.insert(awaited.size(), o);
			if (run + 1 > longest_run)
				longest_run = run + 1;
		endfunction

		function void report_field(string name, logic [63:0] want, logic [63:0] got);
			if (got !== want) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("%0t: %s mismatch, expected %0h, actual %0h",
						$time, name, want, got);
			end
		endfunction

		function void check_result(ocrb_out_t got);
			ocrb_out_t want;
			results_seen++;
			if (awaited.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("%0t: unexpected item, expected none, actual %h",
						$time, got);
				return;
			end
			want = awaited.pop_front();
			if (want.item_kind == KIND_RELEASE)
				releases_seen++;
			report_field("item_kind", 64'(want.item_kind), 64'(got.item_kind));
			report_field("out_begin", want.out_begin, got.out_begin);
			report_field("out_end", want.out_end, got.out_end);
			report_field("out_tag", 64'(want.out_tag), 64'(got.out_tag));
			report_field("write_needed", 64'(want.write_needed), 64'(got.write_needed));
			report_field("input_status", 64'(want.input_status), 64'(got.input_status));
			report_field("last_of_run", 64'(want.last_of_run), 64'(got.last_of_run));
		endfunction
	endclass

endpackage

module offset_chained_reorder_buffer_core_test;
	import ocrb_pkg::*;
	import ocrb_check_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [63:0] OFS_MAX      = '1;
	localparam int          RANDOM_ITEMS = 306;
	localparam int          HOLD_CYCLES  = 400;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_we;
	logic [63:0] cfg_wdata;

	ocrb_chan_if #(.T_t(ocrb_in_t))  batch_ch ();
	ocrb_chan_if #(.T_t(ocrb_out_t)) result_ch ();

	release_predictor predictor = new();
	bit no_idle;
	int n_start_writes;

	offset_chained_reorder_buffer_core #(
		.STORE_DEPTH(STORE_SLOTS)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.batch     (batch_ch),
		.result    (result_ch)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic ocrb_in_t make_batch(logic [63:0] b, logic [63:0] e, logic [15:0] tag,
		logic upd);
		ocrb_in_t it;
		it.window_begin = b;
		it.window_end   = e;
		it.batch_tag    = tag;
		it.has_updates  = upd;
		return it;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_idle || r < 50)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// near zero, near the top of the range, or anywhere
	function automatic logic [63:0] pick_offset();
		int r;
		r = $urandom_range(0, 99);
		if (r < 25)
			return 64'($urandom_range(0, 1000));
		if (r < 50)
			return OFS_MAX - 64'($urandom_range(0, 1000));
		return {$urandom, $urandom};
	endfunction

	task automatic send_batch(input ocrb_in_t it, input int gap);
		@(negedge clk);
		batch_ch.valid <= 1'b1;
		batch_ch.data  <= it;
		do
			@(posedge clk);
		while (batch_ch.ready !== 1'b1);
		predictor.accept_batch(it);
		if (gap > 0) begin
			@(negedge clk);
			batch_ch.valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	task automatic wait_idle();
		@(negedge clk);
		batch_ch.valid <= 1'b0;
		while (predictor.awaited.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_start(input logic [63:0] ofs);
		wait_idle();
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= ofs;
		@(negedge clk);
		cfg_we <= 1'b0;
		predictor.load_start(ofs);
		n_start_writes++;
	endtask

	// result side: random stalls, calm stretches and one long hold-off
	initial begin
		int  stall;
		int  calm;
		int  r;
		bit  held_off;
		stall = 0;
		calm = 0;
		held_off = 1'b0;
		result_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (!held_off && predictor.results_seen >= 80) begin
				held_off = 1'b1;
				result_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			if (calm > 0) begin
				calm--;
				result_ch.ready <= 1'b1;
			end else if (stall > 0) begin
				stall--;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= 1'b1;
				r = $urandom_range(0, 99);
				if (r < 3)
					calm = $urandom_range(50, 150);
				else if (r < 17)
					stall = $urandom_range(1, 3);
				else if (r < 20)
					stall = $urandom_range(10, 40);
			end
			@(posedge clk);
			if (result_ch.valid === 1'b1 && result_ch.ready === 1'b1)
				predictor.check_result(result_ch.data);
		end
	end

	initial begin
		ocrb_in_t    chain[$];
		ocrb_in_t    tmp;
		logic [63:0] ofs[0:16];
		logic [63:0] key;
		int          sent;
		int          len;
		int          i;
		int          j;
		int          r;
		int          keep;

		arst_n          = 1'b0;
		cfg_we          = 1'b0;
		cfg_wdata       = '0;
		batch_ch.valid  = 1'b0;
		batch_ch.data   = '0;
		no_idle         = 1'b0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;

		// directed corners
		write_start('0);
		send_batch(make_batch(64'd0, 64'd10, 16'hFFFF, 1'b1), pick_gap());
		send_batch(make_batch(64'd20, OFS_MAX, 16'h0000, 1'b0), pick_gap());
		// out of order: releases 10 then 20, cursor lands on the top offset
		send_batch(make_batch(64'd10, 64'd20, 16'h1234, 1'b0), pick_gap());
		// window end below begin wraps the cursor back to zero
		send_batch(make_batch(OFS_MAX, 64'd0, 16'h0000, 1'b0), pick_gap());
		for (i = 0; i < STORE_SLOTS; i++)
			send_batch(make_batch(64'd1000 + 64'(i), 64'd1001 + 64'(i), 16'($urandom),
				i[0]), pick_gap());
		// store full even though the key is the expected one
		send_batch(make_batch(64'd0, 64'd7, 16'hBEEF, 1'b1), pick_gap());
		// duplicate is checked before full
		send_batch(make_batch(64'd1003, 64'd9, 16'hCAFE, 1'b0), pick_gap());
		// pending entries released by a cursor move leave with the next item:
		// full drop, then the whole store in one run
		write_start(64'd1000);
		send_batch(make_batch(64'd5, 64'd6, 16'h5A5A, 1'b1), pick_gap());
		write_start(OFS_MAX);
		send_batch(make_batch(OFS_MAX, OFS_MAX, 16'hA5A5, 1'b1), pick_gap());

		// random chains, noise and drains
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			no_idle = ($urandom_range(0, 5) == 0);
			if ($urandom_range(0, 9) < 7) begin
				len = $urandom_range(1, 16);
				ofs[0] = pick_offset();
				for (i = 0; i < len; i++) begin
					r = $urandom_range(0, 99);
					if (r < 80)
						ofs[i + 1] = ofs[i] + 64'($urandom_range(1, 5000));
					else if (r < 90)
						ofs[i + 1] = ofs[i] + {$urandom, $urandom};
					else
						ofs[i + 1] = ofs[i] - 64'($urandom_range(1, 5000));
				end
				write_start(ofs[0]);
				chain.delete();
				for (i = 0; i < len; i++)
					chain.insert(chain.size(), make_batch(ofs[i], ofs[i + 1],
						16'($urandom), 1'($urandom_range(0, 1))));
				if ($urandom_range(0, 7) == 0)
					chain.delete($urandom_range(0, chain.size() - 1));
				r = $urandom_range(0, 3);
				for (j = 0; j < r && chain.size() > 0; j++) begin
					tmp = chain[$urandom_range(0, chain.size() - 1)];
					tmp.window_end = {$urandom, $urandom};
					tmp.batch_tag  = 16'($urandom);
					chain.insert($urandom_range(0, chain.size()), tmp);
				end
				r = $urandom_range(0, 5);
				if (r == 1) begin
					for (i = 0; i < chain.size() / 2; i++) begin
						tmp = chain[i];
						chain[i] = chain[chain.size() - 1 - i];
						chain[chain.size() - 1 - i] = tmp;
					end
				end else if (r > 1) begin
					for (i = chain.size() - 1; i > 0; i--) begin
						j = $urandom_range(0, i);
						tmp = chain[i];
						chain[i] = chain[j];
						chain[j] = tmp;
					end
				end
				foreach (chain[k]) begin
					send_batch(chain[k], pick_gap());
					sent++;
				end
			end else begin
				len = $urandom_range(3, 20);
				for (i = 0; i < len; i++) begin
					send_batch(make_batch(pick_offset(), pick_offset(), 16'($urandom),
						1'($urandom_range(0, 1))), pick_gap());
					sent++;
				end
			end
			// drain: point the cursor at a stored key and resend it as a duplicate
			keep = $urandom_range(0, 6);
			while (predictor.occupancy() > keep) begin
				key = predictor.some_key();
				write_start(key);
				send_batch(make_batch(key, {$urandom, $urandom}, 16'($urandom),
					1'($urandom_range(0, 1))), pick_gap());
				sent++;
			end
		end

		wait_idle();
		repeat (2 * (STORE_SLOTS + 2)) @(negedge clk);
		$display("%0d batches in, %0d results checked, %0d releases, longest run %0d items",
			predictor.batches_in, predictor.results_seen, predictor.releases_seen,
			predictor.longest_run);
		$display("stored %0d, duplicate %0d, store full %0d, start offset writes %0d",
			predictor.n_stored, predictor.n_dup, predictor.n_full, n_start_writes);
		if (predictor.errors == 0 && predictor.awaited.size() == 0)
			$display("offset_chained_reorder_buffer_core_test OK");
		else
			$display("offset_chained_reorder_buffer_core_test NOT OK");
		$finish;
	end

	initial begin
		#15_000_000;
		$display("timeout, %0d items still awaited", predictor.awaited.size());
		$display("offset_chained_reorder_buffer_core_test NOT OK");
		$finish;
	end

endmodule
